/* sv/rrps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rrps_pkg;

  // default number of queue entries
  localparam int QUEUE_DEPTH_DEF = 16;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_MODE  = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_SLICE = 3'd4;

  // stream widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 80;

  // input selector
  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_RUN = 1'b1;

  // scheduling mode
  localparam logic MODE_RR   = 1'b0;
  localparam logic MODE_PRIO = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    STAT_ADDED = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RAN   = 2'd2,
    STAT_EMPTY = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_SHIFT_RD,
    S_SHIFT,
    S_UPDATE,
    S_RESP
  } state_t;

  // one queue entry as stored in the RAM
  typedef struct packed {
    logic [7:0]         number;
    logic [15:0]        burst;
    logic [15:0]        remaining;
    logic signed [15:0] prio;
  } entry_t;

  // one result item
  typedef struct packed {
    status_t            status;
    logic [7:0]         number;
    logic [15:0]        total;
    logic [15:0]        left;
    logic signed [15:0] prio;
    logic               completed;
    logic [15:0]        count;
  } result_t;

  localparam logic signed [15:0] PRIO_MIN = 16'sh8000;
  localparam logic [15:0]        COUNT_MAX = 16'hFFFF;

endpackage
`default_nettype wire

/* sv/round_robin_priority_scheduler.sv */
`timescale 1ns / 1ps
`default_nettype none
// Steps per item, accept to result load: add (accept, queue write, result load);
// round-robin run (accept, head read, update and write-back, result load); priority
// run (accept, a scan reading each queued entry, a shift read and shifts of entries
// ahead of a pick off the head, update, result load). The result is valid the cycle
// after its load; a new item is accepted while that result waits in the output register.
// Synchronous reset empties the queue and clears counters; entries are not cleared.
module round_robin_priority_scheduler #(
  parameter int QUEUE_DEPTH = rrps_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [rrps_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [rrps_pkg::PDATA_W-1:0]      pwdata,
  output logic      [rrps_pkg::PDATA_W-1:0]      prdata,
  output logic                                   pready,
  // input items
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // burst_time[15:0], start_priority[23:16]
  input  wire logic [rrps_pkg::IN_TDATA_W-1:0]   s_tdata,
  // func[0]
  input  wire logic                              s_tuser,
  // result items
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // process_number[7:0], total_burst[23:8], time_left[39:24],
  // priority_used[55:40], completed[56], slice_count[72:57], zero[79:73]
  output logic      [rrps_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // status[1:0]
  output logic      [1:0]                        m_tuser
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = $bits(rrps_pkg::entry_t);

  rrps_pkg::state_t  state, state_next;

  // control registers
  logic [AW-1:0]     head;
  logic [CW-1:0]     occ;
  logic [7:0]        arrival;
  logic [15:0]       slices;
  logic              mode;
  logic [15:0]       slice;
  logic [CW-1:0]     rd_pos;
  logic              out_valid;

  // payload registers
  logic [15:0]       cmd_burst;
  logic [7:0]        cmd_spri;
  logic [CW-1:0]     wr_pos;
  logic [CW-1:0]     cmp_pos;
  logic [CW-1:0]     best_pos;
  rrps_pkg::entry_t  best;
  rrps_pkg::result_t res;
  rrps_pkg::result_t out_res;

  // RAM ports
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  rrps_pkg::entry_t  wr_data;
  logic [AW-1:0]     rd_addr;
  logic [EW-1:0]     rd_raw;
  rrps_pkg::entry_t  rd_entry;

  // shared subtract / compare unit
  logic signed [16:0] sub_a, sub_b, sub_diff;

  logic              accept;
  logic              out_free;
  logic              cfg_wr;
  logic              cand_gt;
  logic              scan_take;
  logic              scan_last;
  logic [CW-1:0]     pick_next;
  logic              upd_done;
  logic [15:0]       upd_rem;
  logic signed [15:0] upd_prio;
  logic [AW-1:0]     head_inc;
  logic              queue_full;

  // queue position to RAM slot, wrapping at the depth
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [CW-1:0] pos);
    logic [AW:0] sum;
    sum = {1'b0, h} + (AW+1)'(pos);
    if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (AW+1)'(QUEUE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  rrps_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_entry = rrps_pkg::entry_t'(rd_raw);

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  always_comb begin
    if ({paddr[2], 2'b00} == rrps_pkg::ADDR_SLICE) begin
      prdata = {16'b0, slice};
    end else begin
      prdata = {31'b0, mode};
    end
  end

  // handshakes
  assign s_tready = (state == rrps_pkg::S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  // shared unit and the decisions taken from it
  assign sub_diff   = sub_a - sub_b;
  assign cand_gt    = !sub_diff[16] && (sub_diff != '0);
  assign scan_take  = (cmp_pos == '0) || cand_gt;
  assign pick_next  = scan_take ? cmp_pos : best_pos;
  assign scan_last  = (mode == rrps_pkg::MODE_RR) || ((cmp_pos + CW'(1)) == occ);
  assign upd_done   = sub_diff[16] || (sub_diff == '0);
  assign upd_rem    = upd_done ? 16'd0 : sub_diff[15:0];
  assign upd_prio   = ((mode == rrps_pkg::MODE_PRIO) && (best.prio != rrps_pkg::PRIO_MIN))
                      ? best.prio - 16'sd1 : best.prio;
  assign head_inc   = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + AW'(1);
  assign queue_full = (occ == CW'(QUEUE_DEPTH));
  assign rd_addr    = slot_of(head, rd_pos);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rrps_pkg::S_IDLE: begin
        if (accept) begin
          if (s_tuser == rrps_pkg::FUNC_ADD) begin
            state_next = rrps_pkg::S_ADD;
          end else if (occ == '0) begin
            state_next = rrps_pkg::S_RESP;
          end else begin
            state_next = rrps_pkg::S_SCAN;
          end
        end
      end
      rrps_pkg::S_ADD:      state_next = rrps_pkg::S_RESP;
      rrps_pkg::S_SCAN: begin
        if (scan_last) begin
          state_next = (pick_next == '0) ? rrps_pkg::S_UPDATE : rrps_pkg::S_SHIFT_RD;
        end
      end
      rrps_pkg::S_SHIFT_RD: state_next = rrps_pkg::S_SHIFT;
      rrps_pkg::S_SHIFT: begin
        if (wr_pos == CW'(1)) begin
          state_next = rrps_pkg::S_UPDATE;
        end
      end
      rrps_pkg::S_UPDATE:   state_next = rrps_pkg::S_RESP;
      rrps_pkg::S_RESP: begin
        if (out_free) begin
          state_next = rrps_pkg::S_IDLE;
        end
      end
      default:              state_next = rrps_pkg::S_IDLE;
    endcase
  end

  // RAM write and shared unit operands
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_of(head, occ);
    wr_data = rd_entry;
    sub_a   = '0;
    sub_b   = '0;
    unique case (state)
      rrps_pkg::S_ADD: begin
        wr_en          = !queue_full;
        wr_data.number    = arrival + 8'd1;
        wr_data.burst     = cmd_burst;
        wr_data.remaining = cmd_burst;
        wr_data.prio      = $signed({8'b0, cmd_spri});
      end
      rrps_pkg::S_SCAN: begin
        sub_a = {rd_entry.prio[15], rd_entry.prio};
        sub_b = {best.prio[15], best.prio};
      end
      rrps_pkg::S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = slot_of(head, wr_pos);
      end
      rrps_pkg::S_UPDATE: begin
        sub_a             = $signed({1'b0, best.remaining});
        sub_b             = $signed({1'b0, slice});
        wr_en             = !upd_done;
        wr_data.number    = best.number;
        wr_data.burst     = best.burst;
        wr_data.remaining = upd_rem;
        wr_data.prio      = upd_prio;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rrps_pkg::S_IDLE;
      head      <= '0;
      occ       <= '0;
      arrival   <= '0;
      slices    <= '0;
      mode      <= rrps_pkg::MODE_RR;
      slice     <= 16'd1;
      rd_pos    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_wr) begin
        if ({paddr[2], 2'b00} == rrps_pkg::ADDR_SLICE) begin
          slice <= pwdata[15:0];
        end else begin
          mode <= pwdata[0];
        end
      end

      if (state == rrps_pkg::S_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        rrps_pkg::S_IDLE: begin
          if (accept && s_tuser == rrps_pkg::FUNC_RUN && occ != '0) begin
            rd_pos <= CW'(1);
          end
        end
        rrps_pkg::S_ADD: begin
          if (!queue_full) begin
            arrival <= arrival + 8'd1;
            occ     <= occ + CW'(1);
          end
        end
        rrps_pkg::S_SCAN: begin
          if (scan_last) begin
            rd_pos <= (pick_next == '0) ? '0 : pick_next - CW'(1);
          end else begin
            rd_pos <= rd_pos + CW'(1);
          end
        end
        rrps_pkg::S_SHIFT_RD, rrps_pkg::S_SHIFT: begin
          if (rd_pos != '0) begin
            rd_pos <= rd_pos - CW'(1);
          end
        end
        rrps_pkg::S_UPDATE: begin
          rd_pos <= '0;
          head   <= head_inc;
          if (upd_done) begin
            occ <= occ - CW'(1);
          end
          if (slices != rrps_pkg::COUNT_MAX) begin
            slices <= slices + 16'd1;
          end
        end
        default: begin
          rd_pos <= rd_pos;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      rrps_pkg::S_IDLE: begin
        if (accept) begin
          cmd_burst <= s_tdata[15:0];
          cmd_spri  <= s_tdata[23:16];
          cmp_pos   <= '0;
          res       <= '{status: rrps_pkg::STAT_EMPTY, number: 8'd0, total: 16'd0,
                         left: 16'd0, prio: 16'sd0, completed: 1'b0, count: slices};
        end
      end
      rrps_pkg::S_ADD: begin
        if (queue_full) begin
          res <= '{status: rrps_pkg::STAT_FULL, number: 8'd0, total: 16'd0,
                   left: 16'd0, prio: 16'sd0, completed: 1'b0, count: slices};
        end else begin
          res <= '{status: rrps_pkg::STAT_ADDED, number: arrival + 8'd1, total: cmd_burst,
                   left: cmd_burst, prio: $signed({8'b0, cmd_spri}), completed: 1'b0,
                   count: slices};
        end
      end
      rrps_pkg::S_SCAN: begin
        cmp_pos <= cmp_pos + CW'(1);
        if (scan_take) begin
          best     <= rd_entry;
          best_pos <= cmp_pos;
        end
        if (scan_last) begin
          wr_pos <= pick_next;
        end
      end
      rrps_pkg::S_SHIFT: begin
        wr_pos <= wr_pos - CW'(1);
      end
      rrps_pkg::S_UPDATE: begin
        res <= '{status: rrps_pkg::STAT_RAN, number: best.number, total: best.burst,
                 left: upd_rem, prio: best.prio, completed: upd_done,
                 count: (slices != rrps_pkg::COUNT_MAX) ? slices + 16'd1 : slices};
      end
      rrps_pkg::S_RESP: begin
        if (out_free) begin
          out_res <= res;
        end
      end
      default: begin
        cmp_pos <= cmp_pos;
      end
    endcase
  end

  // result port
  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.status;
  assign m_tdata  = {7'b0, out_res.count, out_res.completed, out_res.prio,
                     out_res.left, out_res.total, out_res.number};

  // checks
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, head} < (AW+1)'(QUEUE_DEPTH))
    else $error("queue head out of range");

  a_shift_pos: assert property (@(posedge clk) disable iff (rst)
    state == rrps_pkg::S_SHIFT |-> (wr_pos != '0) && (wr_pos < occ))
    else $error("shift position outside the queue");

  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (occ == $past(occ)) || (occ == $past(occ) + CW'(1)) ||
                    (occ == $past(occ) - CW'(1)))
    else $error("occupancy moved by more than one");

endmodule
`default_nettype wire

/* sv/rrps_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module rrps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  wire logic [WIDTH-1:0]             wr_data,
  input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic      [WIDTH-1:0]             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* tb/round_robin_priority_scheduler_tb.sv */
`timescale 1ns / 1ps
module round_robin_priority_scheduler_tb;

  localparam int QDEPTH = rrps_pkg::QUEUE_DEPTH_DEF;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE = 40;

  // one input item as the sender sees it
  typedef struct {
    logic        func;
    logic [15:0] burst;
    logic [7:0]  prio;
  } sched_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [rrps_pkg::PADDR_W-1:0] paddr = '0;
  logic [rrps_pkg::PDATA_W-1:0] pwdata = '0;
  logic [rrps_pkg::PDATA_W-1:0] prdata;
  logic pready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [rrps_pkg::IN_TDATA_W-1:0] s_tdata = '0;   // burst_time[15:0], start_priority[23:16]
  logic s_tuser = 1'b0;                             // func[0]
  logic m_tvalid;
  logic m_tready = 1'b0;
  // process_number[7:0], total_burst[23:8], time_left[39:24],
  // priority_used[55:40], completed[56], slice_count[72:57], zero[79:73]
  logic [rrps_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic [1:0] m_tuser;                              // status[1:0]

  round_robin_priority_scheduler dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Scheduler shadow state
  rrps_pkg::entry_t run_queue[$];
  logic [7:0]  arrivals = '0;
  logic [15:0] slices_done = '0;
  logic        cfg_mode = rrps_pkg::MODE_RR;
  logic [15:0] cfg_slice = 16'd1;

  sched_req_t         sched_items_q[$];
  rrps_pkg::result_t  sched_results_q[$];
  sched_req_t  offered;
  bit          idle_on = 1'b1;
  int          send_gap = 0;
  int          ready_gap = 0;
  int          hold_left = 0;
  int          hold_requests = 0;
  int          holds_served = 0;
  int          error_count = 0;
  int          results_seen = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("mismatch on result %0d: %s got %0h, expected %0h", results_seen, what,
             got, want);
  endtask

  // Expected result of one item; updates the shadow queue and counters
  function automatic rrps_pkg::result_t predict_schedule(input sched_req_t req);
    rrps_pkg::result_t r;
    rrps_pkg::entry_t  e;
    int      pick;
    logic    done;
    r = '0;
    if (req.func == rrps_pkg::FUNC_ADD) begin
      if (run_queue.size() >= QDEPTH) begin
        r.status = rrps_pkg::STAT_FULL;
      end else begin
        arrivals++;
        e.number = arrivals;
        e.burst = req.burst;
        e.remaining = req.burst;
        e.prio = {8'd0, req.prio};
        run_queue.push_back(e);
        r.status = rrps_pkg::STAT_ADDED;
        r.number = arrivals;
        r.total = req.burst;
        r.left = req.burst;
        r.prio = e.prio;
      end
      r.count = slices_done;
    end else if (run_queue.size() == 0) begin
      r.status = rrps_pkg::STAT_EMPTY;
      r.count = slices_done;
    end else begin
      // priority mode: first entry of greatest priority, head first
      pick = 0;
      if (cfg_mode == rrps_pkg::MODE_PRIO)
        for (int i = 1; i < run_queue.size(); i++)
          if ($signed(run_queue[i].prio) > $signed(run_queue[pick].prio)) pick = i;
      e = run_queue[pick];
      run_queue.delete(pick);
      done = (e.remaining <= cfg_slice);
      r.status = rrps_pkg::STAT_RAN;
      r.number = e.number;
      r.total = e.burst;
      r.prio = e.prio;
      r.completed = done;
      r.left = done ? 16'd0 : e.remaining - cfg_slice;
      if (!done) begin
        e.remaining = r.left;
        if (cfg_mode == rrps_pkg::MODE_PRIO && e.prio != rrps_pkg::PRIO_MIN)
          e.prio = e.prio - 16'sd1;
        run_queue.push_back(e);
      end
      if (slices_done != rrps_pkg::COUNT_MAX) slices_done++;
      r.count = slices_done;
    end
    return r;
  endfunction

  // Sender: takes items from the pending queue, random idle bursts
  always @(posedge clk) begin : item_driver
    bit holding;
    holding = s_tvalid;
    if (rst) begin
      holding = 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        sched_results_q.push_back(predict_schedule(offered));
        holding = 1'b0;
      end
      if (!holding) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (sched_items_q.size() > 0) begin
          if (idle_on && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 5);
          end else begin
            offered = sched_items_q.pop_front();
            holding = 1'b1;
          end
        end
      end
    end
    s_tvalid <= holding;
    s_tdata <= {offered.prio, offered.burst};
    s_tuser <= offered.func;
  end

  // Receiver ready: random bursts, plus a long hold on request
  always @(posedge clk) begin : ready_driver
    if (rst) begin
      m_tready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left = LONG_HOLD - 1;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap--;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      ready_gap = $urandom_range(0, 5);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk) begin : result_check
    rrps_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (sched_results_q.size() == 0) begin
        report_mismatch("result with nothing pending", m_tuser, 0);
      end else begin
        want = sched_results_q.pop_front();
        if (m_tuser !== want.status) report_mismatch("status", m_tuser, want.status);
        if (m_tdata[7:0] !== want.number)
          report_mismatch("process_number", m_tdata[7:0], want.number);
        if (m_tdata[23:8] !== want.total)
          report_mismatch("total_burst", m_tdata[23:8], want.total);
        if (m_tdata[39:24] !== want.left)
          report_mismatch("time_left", m_tdata[39:24], want.left);
        if (m_tdata[55:40] !== want.prio)
          report_mismatch("priority_used", m_tdata[55:40], want.prio);
        if (m_tdata[56] !== want.completed)
          report_mismatch("completed", m_tdata[56], want.completed);
        if (m_tdata[72:57] !== want.count)
          report_mismatch("slice_count", m_tdata[72:57], want.count);
        if (m_tdata[79:73] !== '0) report_mismatch("padding", m_tdata[79:73], 0);
      end
    end
  end

  // Register write followed by a read back
  task automatic set_register(input logic [rrps_pkg::PADDR_W-1:0] addr,
                              input logic [31:0] data);
    logic [31:0] want;
    want = (addr == rrps_pkg::ADDR_MODE) ? {31'd0, data[0]} : {16'd0, data[15:0]};
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == rrps_pkg::ADDR_MODE) cfg_mode = data[0];
    else cfg_slice = data[15:0];
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) report_mismatch("register read back", prdata, want);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic queue_item(input logic func, input logic [15:0] burst,
                            input logic [7:0] prio);
    sched_req_t req;
    req.func = func;
    req.burst = burst;
    req.prio = prio;
    sched_items_q.push_back(req);
  endtask

  // Sender pause: everything offered, taken and answered, block settled
  task automatic wait_drained();
    do @(negedge clk);
    while (sched_items_q.size() != 0 || s_tvalid || sched_results_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Random adds and runs; bursts sized around the current slice
  task automatic random_phase(input int count, input int add_pct);
    int   cap;
    logic [15:0] burst;
    logic [7:0]  prio;
    cap = 4 * cfg_slice + 4;
    if (cap > 65535) cap = 65535;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: burst = 16'd0;
        1: burst = 16'hFFFF;
        2: burst = 16'($urandom);
        default: burst = 16'($urandom_range(0, cap));
      endcase
      prio = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3))
                                         : 8'($urandom_range(0, 255));
      queue_item(($urandom_range(1, 100) <= add_pct) ? rrps_pkg::FUNC_ADD
                                                     : rrps_pkg::FUNC_RUN, burst, prio);
    end
  endtask

  initial begin : stimulus
    logic [31:0] slice_val;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty run, edge bursts and priorities, completion, fill to full
    set_register(rrps_pkg::ADDR_MODE, 32'(rrps_pkg::MODE_RR));
    set_register(rrps_pkg::ADDR_SLICE, 32'd3);
    queue_item(rrps_pkg::FUNC_RUN, 16'd0, 8'd0);
    queue_item(rrps_pkg::FUNC_ADD, 16'd0, 8'd0);
    queue_item(rrps_pkg::FUNC_ADD, 16'hFFFF, 8'hFF);
    queue_item(rrps_pkg::FUNC_ADD, 16'd3, 8'd128);
    queue_item(rrps_pkg::FUNC_ADD, 16'd4, 8'd1);
    repeat (4) queue_item(rrps_pkg::FUNC_RUN, 16'hFFFF, 8'hFF);
    for (int i = 0; i < QDEPTH - 1; i++)
      queue_item(rrps_pkg::FUNC_ADD, 16'(i * 4099), 8'(i * 17));
    wait_drained();

    // Random phases over a spread of settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: slice_val = 1;
        1: slice_val = 16'hFFFF;
        2, 3: slice_val = 0;
        4: slice_val = $urandom_range(1, 65535);
        5: slice_val = $urandom_range(1, 20);
        6: slice_val = 16'hFFFF;
        default: slice_val = $urandom_range(1, 8);
      endcase
      set_register(rrps_pkg::ADDR_MODE,
                   (ph % 2 == 0) ? 32'(rrps_pkg::MODE_PRIO) : 32'(rrps_pkg::MODE_RR));
      set_register(rrps_pkg::ADDR_SLICE, slice_val);
      idle_on = (ph != 2 && ph != 5);
      random_phase(70, $urandom_range(25, 75));
      if (ph == 1) hold_requests++;
      wait_drained();
    end

    // No idling from here on: drain the queue, then back-to-back add/run pairs
    idle_on = 1'b0;
    set_register(rrps_pkg::ADDR_MODE, 32'(rrps_pkg::MODE_RR));
    set_register(rrps_pkg::ADDR_SLICE, 32'hFFFF);
    repeat (QDEPTH) queue_item(rrps_pkg::FUNC_RUN, 16'd0, 8'd0);
    repeat (50) begin
      queue_item(rrps_pkg::FUNC_ADD, 16'($urandom), 8'($urandom));
      queue_item(rrps_pkg::FUNC_RUN, 16'd0, 8'd0);
    end
    wait_drained();

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

/* sim.f */
sv/rrps_pkg.sv
sv/rrps_ram.sv
sv/round_robin_priority_scheduler.sv
tb/round_robin_priority_scheduler_tb.sv
